// File: src/tsw_pkg.sv
// Shared types and codes for the task scheduler with sleep and wake queues.
package tsw_pkg;

    localparam logic [2:0] MODE_CREATE = 3'd0;
    localparam logic [2:0] MODE_YIELD  = 3'd1;
    localparam logic [2:0] MODE_SLEEP  = 3'd2;
    localparam logic [2:0] MODE_WAKEUP = 3'd3;
    localparam logic [2:0] MODE_EXIT   = 3'd4;
    localparam logic [2:0] MODE_REAP   = 3'd5;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_NO_SLOT   = 2'd1;
    localparam logic [1:0] STAT_SLEPT     = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] wait_id;
        logic [15:0] target_pid;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] new_pid;
        logic [3:0]  running_slot;
        logic [15:0] running_pid;
        logic        switched;
    } res_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } seq_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_sts_t;

endpackage

// File: src/task_scheduler_fifo_sleep_wake_core.sv
// Top level of the task scheduler with a FIFO ready queue and sleep and wake lists.
//
// The block runs one scheduler command per item and answers with one result item.
// How long it stays busy depends on the command: create scans the slot table one
// slot per cycle, wakeup and exit walk the wait list one waiter at a time because
// each list entry is read through a registered memory read, reap walks the kill
// list the same way, and every command that reschedules pops the ready queue when
// it is not empty and fetches the new task's pid from the pid memory. The shortest
// commands are a yield with an empty queue and an unused mode; the longest is an
// exit that walks a full wait list. Results are held in an output register, so the
// next item is accepted as soon as the sequencer is idle, even while the previous
// result still waits. No clearing pass is needed after reset: slot occupancy is
// kept in flip-flops and the lists are tracked by their counts.
module task_scheduler_fifo_sleep_wake_core #(
    parameter int MAX_TASKS = 16,
    parameter int ID_BITS   = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tsw_pkg::cmd_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tsw_pkg::res_t m_data,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data
);
    logic [15:0]       reap_wait_id_reg;
    logic              m_valid_reg;
    tsw_pkg::res_t     m_data_reg;
    tsw_pkg::seq_ctl_t ctl;
    tsw_pkg::seq_sts_t sts;
    tsw_pkg::res_t     res;

    // The user must write the reaper's wait id only while the block is idle; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reap_wait_id_reg <= 16'd1;
        end else if (cfg_wr_en) begin
            reap_wait_id_reg <= cfg_wr_data;
        end
    end

    assign s_ready      = sts.idle;
    assign ctl.start    = s_valid && sts.idle;
    // The result register is free when empty or being emptied this cycle.
    assign ctl.out_free = !m_valid_reg || m_ready;

    tsw_seq #(
        .MAX_TASKS(MAX_TASKS),
        .ID_BITS  (ID_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .cmd         (s_data),
        .reap_wait_id(reap_wait_id_reg),
        .sts         (sts),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (sts.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sts.done) m_data_reg <= res;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: src/tsw_seq.sv
// Command sequencer with the slot table, ready queue, wait list and kill list.
module tsw_seq #(
    parameter int MAX_TASKS = 16,
    parameter int ID_BITS   = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tsw_pkg::seq_ctl_t ctl,
    input  tsw_pkg::cmd_t     cmd,
    input  logic [15:0]       reap_wait_id,
    output tsw_pkg::seq_sts_t sts,
    output tsw_pkg::res_t     res
);
    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int EW = SW + ID_BITS;
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TASKS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_TASKS - 1);
    localparam logic [ID_BITS-1:0] ID_ONES = {ID_BITS{1'b1}};

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_FREE     = 11'b00000000010,
        ST_WL_RD    = 11'b00000000100,
        ST_WL_PR    = 11'b00000001000,
        ST_KL_RD    = 11'b00000010000,
        ST_KL_PR    = 11'b00000100000,
        ST_SCHED_RD = 11'b00001000000,
        ST_SCHED_PR = 11'b00010000000,
        ST_PID_RD   = 11'b00100000000,
        ST_PID_LD   = 11'b01000000000,
        ST_FIN      = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [MAX_TASKS-1:0] used_reg, used_next;
    logic [SW-1:0]        cur_reg, cur_next;
    logic [ID_BITS-1:0]   cur_pid_reg, cur_pid_next;
    logic [ID_BITS-1:0]   pc_reg, pc_next;
    logic [SW-1:0]        rq_head_reg, rq_head_next;
    logic [CW-1:0]        rq_cnt_reg, rq_cnt_next;
    logic [CW-1:0]        wl_cnt_reg, wl_cnt_next;
    logic [CW-1:0]        kl_cnt_reg, kl_cnt_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        w_reg, w_next;
    logic [SW-1:0]        j_reg, j_next;
    logic                 found_reg, found_next;
    logic                 after_reg, after_next;
    logic [ID_BITS-1:0]   key_reg, key_next;
    logic [1:0]           status_reg, status_next;
    logic [ID_BITS-1:0]   new_pid_reg, new_pid_next;
    logic                 sw_reg, sw_next;

    logic [SW-1:0]      rq_mem [MAX_TASKS];
    logic [EW-1:0]      wl_mem [MAX_TASKS];
    logic [EW-1:0]      kl_mem [MAX_TASKS];
    logic [ID_BITS-1:0] pid_mem [MAX_TASKS];
    logic [SW-1:0]      rq_rd_reg;
    logic [EW-1:0]      wl_rd_reg, kl_rd_reg;
    logic [ID_BITS-1:0] pid_rd_reg;

    logic               rq_we, wl_we, kl_we, pid_we;
    logic [SW-1:0]      rq_wa, wl_wa, kl_wa, pid_wa;
    logic [SW-1:0]      rq_wd;
    logic [EW-1:0]      wl_wd, kl_wd;
    logic [ID_BITS-1:0] pid_wd;
    logic [SW-1:0]      rq_ra, wl_ra, kl_ra, pid_ra;

    logic [SW:0]        tail_sum;
    logic [SW-1:0]      rq_tail;
    logic [ID_BITS-1:0] in_wid, in_tpid, rwid;

    assign in_wid  = ID_BITS'(cmd.wait_id);
    assign in_tpid = ID_BITS'(cmd.target_pid);
    assign rwid    = ID_BITS'(reap_wait_id);

    // Tail of the ring: head plus count, folded once since head < depth and count <= depth.
    assign tail_sum = (SW + 1)'(rq_head_reg) + (SW + 1)'(rq_cnt_reg);
    assign rq_tail  = (tail_sum >= (SW + 1)'(MAX_TASKS))
                      ? SW'(tail_sum - (SW + 1)'(MAX_TASKS)) : SW'(tail_sum);

    always_comb begin
        state_next   = state_reg;
        used_next    = used_reg;
        cur_next     = cur_reg;
        cur_pid_next = cur_pid_reg;
        pc_next      = pc_reg;
        rq_head_next = rq_head_reg;
        rq_cnt_next  = rq_cnt_reg;
        wl_cnt_next  = wl_cnt_reg;
        kl_cnt_next  = kl_cnt_reg;
        i_next       = i_reg;
        w_next       = w_reg;
        j_next       = j_reg;
        found_next   = found_reg;
        after_next   = after_reg;
        key_next     = key_reg;
        status_next  = status_reg;
        new_pid_next = new_pid_reg;
        sw_next      = sw_reg;
        rq_we = 1'b0; rq_wa = rq_tail; rq_wd = cur_reg;
        wl_we = 1'b0; wl_wa = wl_cnt_reg[SW-1:0]; wl_wd = {cur_reg, in_wid};
        kl_we = 1'b0; kl_wa = kl_cnt_reg[SW-1:0]; kl_wd = {cur_reg, cur_pid_reg};
        pid_we = 1'b0; pid_wa = j_reg; pid_wd = pc_reg;
        rq_ra = rq_head_reg;
        wl_ra = i_reg[SW-1:0];
        kl_ra = i_reg[SW-1:0];
        pid_ra = cur_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (ctl.start) begin
                    status_next  = tsw_pkg::STAT_DONE;
                    new_pid_next = '0;
                    sw_next      = 1'b0;
                    i_next       = '0;
                    w_next       = '0;
                    j_next       = '0;
                    found_next   = 1'b0;
                    after_next   = 1'b0;
                    unique case (cmd.mode)
                        tsw_pkg::MODE_CREATE: state_next = ST_FREE;
                        tsw_pkg::MODE_YIELD: begin
                            if (rq_cnt_reg == '0) begin
                                state_next = ST_FIN;
                            end else begin
                                sw_next = 1'b1;
                                if (cur_reg != '0 && rq_cnt_reg < FULL_CNT) begin
                                    rq_we       = 1'b1;
                                    rq_cnt_next = rq_cnt_reg + 1'b1;
                                end
                                state_next = ST_SCHED_RD;
                            end
                        end
                        tsw_pkg::MODE_SLEEP: begin
                            sw_next = 1'b1;
                            if (cur_reg != '0 && wl_cnt_reg < FULL_CNT) begin
                                wl_we       = 1'b1;
                                wl_cnt_next = wl_cnt_reg + 1'b1;
                            end
                            state_next = ST_SCHED_RD;
                        end
                        tsw_pkg::MODE_WAKEUP: begin
                            key_next   = in_wid;
                            state_next = ST_WL_RD;
                        end
                        tsw_pkg::MODE_EXIT: begin
                            sw_next    = 1'b1;
                            after_next = 1'b1;
                            key_next   = rwid;
                            if (cur_reg != '0 && kl_cnt_reg < FULL_CNT) begin
                                kl_we       = 1'b1;
                                kl_cnt_next = kl_cnt_reg + 1'b1;
                            end
                            state_next = ST_WL_RD;
                        end
                        tsw_pkg::MODE_REAP: begin
                            key_next = in_tpid;
                            if (kl_cnt_reg == '0) begin
                                status_next = tsw_pkg::STAT_SLEPT;
                                sw_next     = 1'b1;
                                wl_wd       = {cur_reg, rwid};
                                if (cur_reg != '0 && wl_cnt_reg < FULL_CNT) begin
                                    wl_we       = 1'b1;
                                    wl_cnt_next = wl_cnt_reg + 1'b1;
                                end
                                state_next = ST_SCHED_RD;
                            end else begin
                                state_next = ST_KL_RD;
                            end
                        end
                        default: state_next = ST_FIN;
                    endcase
                end
            end
            ST_FREE: begin
                if (!used_reg[j_reg]) begin
                    used_next[j_reg] = 1'b1;
                    pid_we       = 1'b1;
                    new_pid_next = pc_reg;
                    pc_next      = (pc_reg == ID_ONES) ? ID_BITS'(1) : pc_reg + 1'b1;
                    rq_wd        = j_reg;
                    if (rq_cnt_reg < FULL_CNT) begin
                        rq_we       = 1'b1;
                        rq_cnt_next = rq_cnt_reg + 1'b1;
                    end
                    state_next = ST_FIN;
                end else if (j_reg == LAST_SLOT) begin
                    status_next = tsw_pkg::STAT_NO_SLOT;
                    state_next  = ST_FIN;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_WL_RD: begin
                if (i_reg == wl_cnt_reg) begin
                    wl_cnt_next = w_reg;
                    state_next  = after_reg ? ST_SCHED_RD : ST_FIN;
                end else begin
                    state_next = ST_WL_PR;
                end
            end
            ST_WL_PR: begin
                // Matching waiters go to the ready queue when it has room; the rest close up in order.
                if (wl_rd_reg[ID_BITS-1:0] == key_reg) begin
                    rq_wd = wl_rd_reg[EW-1:ID_BITS];
                    if (rq_cnt_reg < FULL_CNT) begin
                        rq_we       = 1'b1;
                        rq_cnt_next = rq_cnt_reg + 1'b1;
                    end
                end else begin
                    wl_we  = 1'b1;
                    wl_wa  = w_reg[SW-1:0];
                    wl_wd  = wl_rd_reg;
                    w_next = w_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = ST_WL_RD;
            end
            ST_KL_RD: begin
                if (i_reg == kl_cnt_reg) begin
                    kl_cnt_next = w_reg;
                    status_next = found_reg ? tsw_pkg::STAT_DONE : tsw_pkg::STAT_NOT_FOUND;
                    state_next  = ST_FIN;
                end else begin
                    state_next = ST_KL_PR;
                end
            end
            ST_KL_PR: begin
                if (!found_reg && kl_rd_reg[ID_BITS-1:0] == key_reg) begin
                    found_next = 1'b1;
                    used_next[kl_rd_reg[EW-1:ID_BITS]] = 1'b0;
                end else begin
                    kl_we  = 1'b1;
                    kl_wa  = w_reg[SW-1:0];
                    kl_wd  = kl_rd_reg;
                    w_next = w_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = ST_KL_RD;
            end
            ST_SCHED_RD: begin
                if (rq_cnt_reg == '0) begin
                    cur_next   = '0;
                    state_next = ST_PID_RD;
                end else begin
                    state_next = ST_SCHED_PR;
                end
            end
            ST_SCHED_PR: begin
                cur_next     = rq_rd_reg;
                rq_head_next = (rq_head_reg == LAST_SLOT) ? '0 : rq_head_reg + 1'b1;
                rq_cnt_next  = rq_cnt_reg - 1'b1;
                state_next   = ST_PID_RD;
            end
            ST_PID_RD: state_next = ST_PID_LD;
            ST_PID_LD: begin
                // The idle task never has a pid entry written.
                cur_pid_next = (cur_reg == '0) ? '0 : pid_rd_reg;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                if (ctl.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= MAX_TASKS'(1);
            cur_reg     <= '0;
            cur_pid_reg <= '0;
            pc_reg      <= ID_BITS'(1);
            rq_head_reg <= '0;
            rq_cnt_reg  <= '0;
            wl_cnt_reg  <= '0;
            kl_cnt_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            cur_reg     <= cur_next;
            cur_pid_reg <= cur_pid_next;
            pc_reg      <= pc_next;
            rq_head_reg <= rq_head_next;
            rq_cnt_reg  <= rq_cnt_next;
            wl_cnt_reg  <= wl_cnt_next;
            kl_cnt_reg  <= kl_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        w_reg       <= w_next;
        j_reg       <= j_next;
        found_reg   <= found_next;
        after_reg   <= after_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        new_pid_reg <= new_pid_next;
        sw_reg      <= sw_next;
    end

    always_ff @(posedge aclk) begin
        if (rq_we) rq_mem[rq_wa] <= rq_wd;
        rq_rd_reg <= rq_mem[rq_ra];
    end

    always_ff @(posedge aclk) begin
        if (wl_we) wl_mem[wl_wa] <= wl_wd;
        wl_rd_reg <= wl_mem[wl_ra];
    end

    always_ff @(posedge aclk) begin
        if (kl_we) kl_mem[kl_wa] <= kl_wd;
        kl_rd_reg <= kl_mem[kl_ra];
    end

    always_ff @(posedge aclk) begin
        if (pid_we) pid_mem[pid_wa] <= pid_wd;
        pid_rd_reg <= pid_mem[pid_ra];
    end

    assign sts.idle = (state_reg == ST_IDLE);
    assign sts.done = (state_reg == ST_FIN) && ctl.out_free;

    assign res.status       = status_reg;
    assign res.new_pid      = 16'(new_pid_reg);
    assign res.running_slot = 4'(cur_reg);
    assign res.running_pid  = 16'(cur_pid_reg);
    assign res.switched     = sw_reg;

endmodule
